// ----- rtl/hmac_md5_engine_assert.svh -----
// ---------------------------------------------------------------------------
// hmac_md5_engine_assert
// Assertion macros used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef HMAC_MD5_ENGINE_ASSERT_SVH
`define HMAC_MD5_ENGINE_ASSERT_SVH

// Same-cycle implication, reset masked.
`define HMD5_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define HMD5_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hmd5_pkg.sv -----
// ---------------------------------------------------------------------------
// hmd5_pkg
// Shared types, constants and MD5 round tables for the HMAC-MD5 engine.
// ---------------------------------------------------------------------------
package hmd5_pkg;

	localparam logic [1:0] OP_KEY = 2'd0;
	localparam logic [1:0] OP_MSG = 2'd1;
	localparam logic [1:0] OP_END = 2'd2;

	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5C;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
	} req_beat_t;

	typedef struct packed {
		logic [63:0] tag_high;
		logic [63:0] tag_low;
	} rsp_beat_t;

	// sequencer -> hash core
	typedef struct packed {
		logic       init;
		logic       push;
		logic [7:0] data;
	} core_ctl_t;

	typedef logic [3:0][31:0] chain_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// rotate amount, indexed by {round group, round mod 4}
	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word schedule
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		logic [3:0] r;
		r = i[3:0];
		unique case (i[5:4])
			2'd0: g = r;
			2'd1: g = 4'((r << 2) + r + 4'd1);
			2'd2: g = 4'((r << 1) + r + 4'd5);
			2'd3: g = 4'((r << 3) - r);
			default: g = r;
		endcase
		return g;
	endfunction

endpackage

// ----- rtl/hmd5_core.sv -----
// ---------------------------------------------------------------------------
// hmd5_core
// MD5 block buffer and compression unit, one round per cycle.
// ---------------------------------------------------------------------------
module hmd5_core (
	input  logic                clk,
	input  logic                arst_n,
	input  hmd5_pkg::core_ctl_t ctl,
	output logic                busy,
	output logic [5:0]          fill,
	output hmd5_pkg::chain_t    chain
);

	logic [15:0][31:0] blk_q;
	logic [5:0]        fill_q;
	logic [5:0]        rnd_q;
	logic              run_q;
	logic              add_q;
	hmd5_pkg::chain_t  chain_q;
	logic [31:0]       a_q, b_q, c_q, d_q;

	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] dbl;
	logic [31:0] b_nxt;

	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = '0;
		endcase
		sum = a_q + f + hmd5_pkg::md5_k(rnd_q) + blk_q[hmd5_pkg::md5_g(rnd_q)];
		dbl = {sum, sum} << hmd5_pkg::md5_s(rnd_q);
		b_nxt = b_q + dbl[63:32];
	end

	// block buffer, byte-wide writes, little-endian words
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			blk_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			rnd_q   <= '0;
			run_q   <= 1'b0;
			add_q   <= 1'b0;
			chain_q <= {hmd5_pkg::IV3, hmd5_pkg::IV2, hmd5_pkg::IV1, hmd5_pkg::IV0};
		end else begin
			if (ctl.init) begin
				fill_q  <= '0;
				chain_q <= {hmd5_pkg::IV3, hmd5_pkg::IV2, hmd5_pkg::IV1, hmd5_pkg::IV0};
			end else if (ctl.push) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == 6'd63) begin
					run_q <= 1'b1;
					rnd_q <= '0;
				end
			end
			if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q <= 1'b0;
					add_q <= 1'b1;
				end
			end
			if (add_q) begin
				add_q      <= 1'b0;
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.push && fill_q == 6'd63) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (run_q) begin
			a_q <= d_q;
			b_q <= b_nxt;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	assign busy  = run_q | add_q;
	assign fill  = fill_q;
	assign chain = chain_q;

endmodule

// ----- rtl/hmac_md5_engine.sv -----
// ---------------------------------------------------------------------------
// hmac_md5_engine
// HMAC-MD5 tag engine: key bytes, message bytes, then an end beat that
// returns the 16-byte tag.
//
//   channel | dir | payload                  | handshake
//   --------+-----+--------------------------+-------------------------
//   req     | in  | op, data_byte            | req_valid / req_stall
//   rsp     | out | tag_high, tag_low        | rsp_valid / rsp_stall
//
// A short-key byte is only stored. A message beat, or a key beat once the key
// runs past 64 bytes, goes through accept, dispatch, push and dispatch, plus a
// block compression when its byte completes a 64-byte block (64 rounds plus
// the chain add). A beat that opens the message first hashes the 64-byte
// padded key; the end beat runs 3 to 6 block compressions with their byte
// pushes.
// Reset restores the MD5 initial chain, clears the key and waits for a key.
// req_stall is high while a beat is being worked on; a held tag in the
// output register stalls only the next end beat, not other beats.
// ---------------------------------------------------------------------------
module hmac_md5_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  hmd5_pkg::req_beat_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output hmd5_pkg::rsp_beat_t rsp
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DISP = 9'b000000010,
		ST_KEYF = 9'b000000100,
		ST_BYTE = 9'b000001000,
		ST_PAD  = 9'b000010000,
		ST_LEN  = 9'b000100000,
		ST_FIN  = 9'b001000000,
		ST_DIG  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		PH_AWAIT = 2'd0,
		PH_LONG  = 2'd1,
		PH_MSG   = 2'd2
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [6:0]        kcnt_q;     // saturates at 64, only "< 64" matters
	logic [15:0][31:0] key_q;
	logic [7:0]        b_q;
	logic [7:0]        pad_q;
	// pending work for the current beat
	logic              fin_key_q;  // finish long-key hash, digest becomes key
	logic              open_q;     // restart hash with padded key
	logic              feed_q;     // hash the beat's byte
	logic              digp_q;     // hash the inner digest
	logic              tag_q;      // finish hash (inner, then outer)
	logic              stage_q;    // 0 inner pass, 1 outer pass
	logic              pfirst_q;
	logic [5:0]        idx_q;
	logic [63:0]       len_q;
	hmd5_pkg::chain_t  dgst_q;
	logic              rsp_valid_q;
	hmd5_pkg::rsp_beat_t rsp_q;

	hmd5_pkg::core_ctl_t ctl;
	logic                core_busy;
	logic [5:0]          core_fill;
	hmd5_pkg::chain_t    chain;

	logic                acc;
	logic [63:0]         bits;
	hmd5_pkg::rsp_beat_t tag;

	hmd5_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.busy   (core_busy),
		.fill   (core_fill),
		.chain  (chain)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign acc       = req_valid && !req_stall;
	assign bits      = {len_q[60:0], 3'b000};

	// byte source for the hash core
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_KEYF: begin
				ctl.push = !core_busy;
				ctl.data = key_q[idx_q[5:2]][{idx_q[1:0], 3'b000} +: 8] ^ pad_q;
			end
			ST_BYTE: begin
				ctl.push = !core_busy;
				ctl.data = b_q;
			end
			ST_PAD: begin
				ctl.push = !core_busy;
				ctl.data = pfirst_q ? hmd5_pkg::PAD_MARK : 8'h00;
			end
			ST_LEN: begin
				ctl.push = !core_busy;
				ctl.data = bits[{idx_q[2:0], 3'b000} +: 8];
			end
			ST_DIG: begin
				ctl.push = !core_busy;
				ctl.data = dgst_q[idx_q[3:2]][{idx_q[1:0], 3'b000} +: 8];
			end
			ST_DISP: ctl.init = !core_busy && !fin_key_q && open_q;
			ST_OUT:  ctl.init = !rsp_valid_q;
			ST_IDLE, ST_FIN: ctl = '0;
			default: ctl = '0;
		endcase
	end

	// tag bytes, byte 0 most significant; MD5 digest bytes are little-endian
	always_comb begin
		tag = '0;
		for (int i = 0; i < 8; i++) begin
			tag.tag_high[63 - 8*i -: 8] = chain[i/4][8*(i%4) +: 8];
			tag.tag_low[63 - 8*i -: 8]  = chain[2 + i/4][8*(i%4) +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_AWAIT;
			kcnt_q      <= '0;
			key_q       <= '0;
			b_q         <= '0;
			pad_q       <= '0;
			fin_key_q   <= 1'b0;
			open_q      <= 1'b0;
			feed_q      <= 1'b0;
			digp_q      <= 1'b0;
			tag_q       <= 1'b0;
			stage_q     <= 1'b0;
			pfirst_q    <= 1'b0;
			idx_q       <= '0;
			len_q       <= '0;
			dgst_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						b_q <= req.data_byte;
						unique case (req.op)
							hmd5_pkg::OP_KEY: begin
								if (phase_q != PH_MSG) begin
									if (kcnt_q != 7'd64) begin
										kcnt_q <= kcnt_q + 7'd1;
									end
									if (phase_q == PH_AWAIT && kcnt_q != 7'd64) begin
										key_q[kcnt_q[5:2]][{kcnt_q[1:0], 3'b000} +: 8]
											<= req.data_byte;
									end else begin
										// long key: hash the stored key plain, then this byte
										if (phase_q == PH_AWAIT) begin
											open_q <= 1'b1;
											pad_q  <= 8'h00;
										end
										phase_q <= PH_LONG;
										feed_q  <= 1'b1;
										state_q <= ST_DISP;
									end
								end
							end
							hmd5_pkg::OP_MSG, hmd5_pkg::OP_END: begin
								fin_key_q <= (phase_q == PH_LONG);
								open_q    <= (phase_q != PH_MSG);
								pad_q     <= hmd5_pkg::IPAD;
								feed_q    <= (req.op == hmd5_pkg::OP_MSG);
								tag_q     <= (req.op == hmd5_pkg::OP_END);
								stage_q   <= 1'b0;
								phase_q   <= PH_MSG;
								state_q   <= ST_DISP;
							end
							default: ;
						endcase
					end
				end
				ST_DISP: begin
					if (!core_busy) begin
						idx_q <= '0;
						priority if (fin_key_q) begin
							pfirst_q <= 1'b1;
							state_q  <= ST_PAD;
						end else if (open_q) begin
							len_q   <= '0;
							state_q <= ST_KEYF;
						end else if (feed_q) begin
							state_q <= ST_BYTE;
						end else if (digp_q) begin
							state_q <= ST_DIG;
						end else if (tag_q) begin
							pfirst_q <= 1'b1;
							state_q  <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_KEYF: begin
					if (!core_busy) begin
						len_q <= len_q + 64'd1;
						idx_q <= idx_q + 6'd1;
						if (idx_q == 6'd63) begin
							open_q  <= 1'b0;
							state_q <= ST_DISP;
						end
					end
				end
				ST_BYTE: begin
					if (!core_busy) begin
						len_q   <= len_q + 64'd1;
						feed_q  <= 1'b0;
						state_q <= ST_DISP;
					end
				end
				ST_DIG: begin
					if (!core_busy) begin
						len_q <= len_q + 64'd1;
						idx_q <= idx_q + 6'd1;
						if (idx_q == 6'd15) begin
							digp_q  <= 1'b0;
							state_q <= ST_DISP;
						end
					end
				end
				ST_PAD: begin
					if (!core_busy) begin
						pfirst_q <= 1'b0;
						if (core_fill == 6'd55) begin
							idx_q   <= '0;
							state_q <= ST_LEN;
						end
					end
				end
				ST_LEN: begin
					if (!core_busy) begin
						idx_q <= idx_q + 6'd1;
						if (idx_q == 6'd7) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (!core_busy) begin
						priority if (fin_key_q) begin
							// digest replaces the key, rest zero
							key_q       <= {{12{32'h0}}, chain};
							fin_key_q   <= 1'b0;
							state_q     <= ST_DISP;
						end else if (!stage_q) begin
							dgst_q  <= chain;
							stage_q <= 1'b1;
							open_q  <= 1'b1;
							pad_q   <= hmd5_pkg::OPAD;
							digp_q  <= 1'b1;
							state_q <= ST_DISP;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q) begin
						rsp_q       <= tag;
						rsp_valid_q <= 1'b1;
						key_q       <= '0;
						kcnt_q      <= '0;
						phase_q     <= PH_AWAIT;
						tag_q       <= 1'b0;
						stage_q     <= 1'b0;
						len_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/hmd5_checker.sv -----
// ---------------------------------------------------------------------------
// hmd5_checker
// Port-level checks for hmac_md5_engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "hmac_md5_engine_assert.svh"

module hmd5_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input hmd5_pkg::req_beat_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input hmd5_pkg::rsp_beat_t rsp
);

	logic acc_end;
	logic acc_msg;
	logic rsp_held;

	assign acc_end  = req_valid && !req_stall && req.op == hmd5_pkg::OP_END;
	assign acc_msg  = req_valid && !req_stall && req.op == hmd5_pkg::OP_MSG;
	assign rsp_held = rsp_valid && rsp_stall;

	`HMD5_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp), "stalled tag changed")
	`HMD5_ASSERT_NEXT(a_end_busy, acc_end, req_stall, "end beat did not start tag work")
	`HMD5_ASSERT_NEXT(a_msg_busy, acc_msg, req_stall, "message beat not hashed")
	`HMD5_ASSERT_NOW(a_tag_src, $rose(rsp_valid), $past(req_stall), "tag without busy sequencer")

endmodule

bind hmac_md5_engine hmd5_checker u_hmd5_checker (.*);

// ----- tb/hmac_md5_engine_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hmac_md5_engine_tb
// Self-checking bench for the HMAC-MD5 tag engine. A queue of request beats
// feeds a clocked driver. A bit-accurate HMAC-MD5 model predicts each tag on
// acceptance. A clocked monitor checks every response beat against the
// oldest predicted tag. Directed corner cases come first, then random key
// and message sequences under changing idle patterns, a long response
// hold-off and a 200-byte key.
// ---------------------------------------------------------------------------
module hmac_md5_engine_tb;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 1000;  // time for a trailing end beat to finish
	localparam int KEY_SAT = 131071;      // model's key counter saturates here
	localparam int LONG_KEY_LEN = 200;
	localparam logic [1:0] OP_NONE = 2'd3; // unused op code, ignored by the block

	// MD5 additive constants and rotate amounts
	localparam logic [31:0] SINE_K [0:63] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int ROT_AMT [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20,
		4, 11, 16, 23, 6, 10, 15, 21};

	typedef enum logic [1:0] {
		AWAIT_KEY = 2'd0,
		LONG_KEY  = 2'd1,
		IN_MSG    = 2'd2
	} hmac_phase_e;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	hmd5_pkg::req_beat_t req;
	logic                rsp_valid;
	logic                rsp_stall;
	hmd5_pkg::rsp_beat_t rsp;

	hmac_md5_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// stimulus and scoreboard storage
	hmd5_pkg::req_beat_t beat_q[$];
	hmd5_pkg::rsp_beat_t tag_q[$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;       // bumped by the stimulus to ask for a long hold-off
	int hold_seen;
	int hold_left;
	int err_count;
	int tags_checked;
	int beats_sent;
	int cycle_count = 0;

	// ------------------------------------------------------------------
	// HMAC-MD5 model state
	// ------------------------------------------------------------------
	logic [31:0] hm_chain [4];
	logic [7:0]  hm_block [64];
	int          hm_fill;
	logic [63:0] hm_len;
	logic [7:0]  hm_key [64];
	int          hm_key_cnt;
	hmac_phase_e hm_phase;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic void md5_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		for (int i = 0; i < 16; i++)
			w[i] = {hm_block[4*i+3], hm_block[4*i+2], hm_block[4*i+1], hm_block[4*i]};
		a = hm_chain[0]; b = hm_chain[1]; c = hm_chain[2]; d = hm_chain[3];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c); g = (5*i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3*i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7*i) % 16;
			end
			t = d; d = c; c = b;
			b = b + rotl(a + f + SINE_K[i] + w[g], ROT_AMT[(i/16)*4 + i%4]);
			a = t;
		end
		hm_chain[0] += a; hm_chain[1] += b; hm_chain[2] += c; hm_chain[3] += d;
	endfunction

	function automatic void md5_restart();
		hm_chain[0] = 32'h67452301; hm_chain[1] = 32'hefcdab89;
		hm_chain[2] = 32'h98badcfe; hm_chain[3] = 32'h10325476;
		hm_fill = 0;
		hm_len = '0;
	endfunction

	// raw byte into the block buffer; counts toward the length via md5_byte
	function automatic void md5_put(input logic [7:0] v);
		hm_block[hm_fill % 64] = v;
		hm_fill = (hm_fill + 1) % 128;
		if (hm_fill >= 64) begin
			md5_block();
			hm_fill = 0;
		end
	endfunction

	function automatic void md5_byte(input logic [7:0] v);
		md5_put(v);
		hm_len++;
	endfunction

	function automatic void md5_close(output logic [7:0] dg [16]);
		logic [63:0] bits;
		bits = hm_len << 3;
		md5_put(hmd5_pkg::PAD_MARK);
		while (hm_fill != 56) md5_put(8'h00);
		for (int i = 0; i < 8; i++) md5_put(bits[8*i +: 8]);
		for (int i = 0; i < 16; i++) dg[i] = hm_chain[i/4][8*(i%4) +: 8];
	endfunction

	// long key is replaced by its digest, then the inner hash gets key ^ ipad
	function automatic void open_inner();
		logic [7:0] dg [16];
		if (hm_phase == LONG_KEY) begin
			md5_close(dg);
			for (int i = 0; i < 64; i++) hm_key[i] = (i < 16) ? dg[i] : 8'h00;
		end
		md5_restart();
		for (int i = 0; i < 64; i++) md5_byte(hm_key[i] ^ hmd5_pkg::IPAD);
		hm_phase = IN_MSG;
	endfunction

	function automatic void hmac_reset();
		md5_restart();
		for (int i = 0; i < 64; i++) begin
			hm_block[i] = 8'h00;
			hm_key[i] = 8'h00;
		end
		hm_key_cnt = 0;
		hm_phase = AWAIT_KEY;
	endfunction

	// apply one accepted beat; a finished tag goes onto tag_q
	function automatic void hmac_apply(input hmd5_pkg::req_beat_t bt);
		logic [7:0] inner [16];
		logic [7:0] outer [16];
		hmd5_pkg::rsp_beat_t tg;
		case (bt.op)
			hmd5_pkg::OP_KEY: begin
				if (hm_phase != IN_MSG) begin
					if (hm_phase == LONG_KEY) begin
						md5_byte(bt.data_byte);
					end else if (hm_key_cnt < 64) begin
						hm_key[hm_key_cnt] = bt.data_byte;
					end else begin
						// 65th byte: start hashing the whole key
						md5_restart();
						for (int i = 0; i < 64; i++) md5_byte(hm_key[i]);
						md5_byte(bt.data_byte);
						hm_phase = LONG_KEY;
					end
					if (hm_key_cnt < KEY_SAT) hm_key_cnt++;
				end
			end
			hmd5_pkg::OP_MSG: begin
				if (hm_phase != IN_MSG) open_inner();
				md5_byte(bt.data_byte);
			end
			hmd5_pkg::OP_END: begin
				if (hm_phase != IN_MSG) open_inner();
				md5_close(inner);
				md5_restart();
				for (int i = 0; i < 64; i++) md5_byte(hm_key[i] ^ hmd5_pkg::OPAD);
				for (int i = 0; i < 16; i++) md5_byte(inner[i]);
				md5_close(outer);
				for (int i = 0; i < 8; i++) begin
					tg.tag_high[63 - 8*i -: 8] = outer[i];
					tg.tag_low[63 - 8*i -: 8] = outer[8 + i];
				end
				tag_q.push_back(tg);
				for (int i = 0; i < 64; i++) hm_key[i] = 8'h00;
				hm_key_cnt = 0;
				hm_phase = AWAIT_KEY;
				md5_restart();
			end
			default: ; // unused op code: no effect
		endcase
	endfunction

	// ------------------------------------------------------------------
	// clock, reset, cycle limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tags outstanding",
				cycle_count, tag_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// driver: presents queued beats; the model sees each beat on acceptance
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				hmac_apply(req);
				beats_sent++;
			end
			// a stalled beat holds; otherwise pick the next one or idle
			if (!req_valid || !req_stall) begin
				if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= beat_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver stall: random idling plus an occasional long hold-off
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 3000;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// monitor: each accepted tag against the oldest prediction
	// ------------------------------------------------------------------
	task automatic report(input string what, input logic [63:0] got,
		input logic [63:0] want);
		err_count++;
		$display("[%0t] tag %0d %s: got %016h want %016h",
			$realtime, tags_checked, what, got, want);
	endtask

	always @(posedge clk) begin
		hmd5_pkg::rsp_beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (tag_q.size() == 0) begin
				report("unexpected beat", rsp.tag_high, '0);
			end else begin
				want = tag_q.pop_front();
				if (rsp.tag_high !== want.tag_high)
					report("tag_high", rsp.tag_high, want.tag_high);
				if (rsp.tag_low !== want.tag_low)
					report("tag_low", rsp.tag_low, want.tag_low);
			end
			tags_checked++;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic void put_beat(input logic [1:0] op, input logic [7:0] b);
		hmd5_pkg::req_beat_t bt;
		bt.op = op;
		bt.data_byte = b;
		beat_q.push_back(bt);
	endfunction

	// one key/message/end sequence with random content; returns key, message and end beats queued, noise not counted
	function automatic int add_sequence();
		int klen, mlen, n, sel;
		sel = $urandom_range(99);
		if (sel < 65) klen = $urandom_range(20);
		else if (sel < 80) klen = $urandom_range(70, 60);
		else if (sel < 90) klen = $urandom_range(150, 64);
		else klen = 0;
		sel = $urandom_range(99);
		if (sel < 70) mlen = $urandom_range(40);
		else if (sel < 90) mlen = $urandom_range(130, 50);
		else mlen = 0;
		n = 0;
		for (int i = 0; i < klen; i++) begin
			put_beat(hmd5_pkg::OP_KEY, 8'($urandom));
			n++;
		end
		for (int i = 0; i < mlen; i++) begin
			// noise: key bytes after the message began and the unused op code
			sel = $urandom_range(99);
			if (sel < 3) put_beat(hmd5_pkg::OP_KEY, 8'($urandom));
			else if (sel < 5) put_beat(OP_NONE, 8'($urandom));
			put_beat(hmd5_pkg::OP_MSG, 8'($urandom));
			n++;
		end
		// broken sequence now and then: no end beat, next sequence's message bytes pile on
		if ($urandom_range(99) >= 6) begin
			put_beat(hmd5_pkg::OP_END, 8'($urandom));
			n++;
		end
		return n;
	endfunction

	task automatic run_random(input int count);
		int n;
		n = 0;
		while (n < count) n += add_sequence();
	endtask

	// all beats out, all tags back, then let a trailing beat finish
	task automatic drain();
		while (beat_q.size() > 0 || req_valid || tag_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 0;
		err_count = 0;
		tags_checked = 0;
		beats_sent = 0;
		hmac_reset();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes, each op, empty key, empty message,
		// key byte after message start, unused op code
		put_beat(hmd5_pkg::OP_KEY, 8'h00); put_beat(hmd5_pkg::OP_KEY, 8'hFF);
		put_beat(hmd5_pkg::OP_MSG, 8'h00); put_beat(hmd5_pkg::OP_MSG, 8'hFF);
		put_beat(hmd5_pkg::OP_MSG, 8'hAA);
		put_beat(hmd5_pkg::OP_END, 8'h00);
		put_beat(hmd5_pkg::OP_END, 8'hFF);
		put_beat(hmd5_pkg::OP_KEY, 8'h55); put_beat(hmd5_pkg::OP_END, 8'h00);
		put_beat(hmd5_pkg::OP_MSG, 8'h12); put_beat(hmd5_pkg::OP_KEY, 8'h34);
		put_beat(OP_NONE, 8'hFF); put_beat(hmd5_pkg::OP_MSG, 8'h56);
		put_beat(hmd5_pkg::OP_END, 8'h00);
		put_beat(OP_NONE, 8'h00); put_beat(hmd5_pkg::OP_END, 8'h5A);
		drain();

		// sender idles lightly, receiver heavily
		send_idle_pct = 17;
		recv_idle_pct = 46;
		run_random(500);
		drain();

		// long receiver hold-off while short sequences pile up behind it
		hold_req++;
		for (int i = 0; i < 4; i++) begin
			put_beat(hmd5_pkg::OP_KEY, 8'($urandom));
			put_beat(hmd5_pkg::OP_MSG, 8'($urandom));
			put_beat(hmd5_pkg::OP_END, 8'h00);
		end
		drain();

		send_idle_pct = 46;
		recv_idle_pct = 17;
		run_random(500);
		drain();

		// no idling; ends with one 200-byte key
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(500);
		for (int i = 0; i < LONG_KEY_LEN; i++) put_beat(hmd5_pkg::OP_KEY, 8'($urandom));
		put_beat(hmd5_pkg::OP_MSG, 8'hC3);
		put_beat(hmd5_pkg::OP_END, 8'h00);
		drain();

		$display("covered %0d request beats and %0d tags: short and long keys,",
			beats_sent, tags_checked);
		$display("empty keys and messages, ignored beats, idle mixes and a long hold-off");
		if (err_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", err_count);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
